// ----- src/mqre_pkg.sv -----
// ----------------------------------------------------------------------------
// mqre_pkg
// Types and codes shared by the message queue, its cells and its checker.
// ----------------------------------------------------------------------------
package mqre_pkg;

  // Operation codes of a request transaction
  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Message types
  typedef enum logic [1:0] {
    MT_READY    = 2'd0,
    MT_REQUEST  = 2'd1,
    MT_RESPONSE = 2'd2,
    MT_UNKNOWN  = 2'd3
  } msg_type_t;

  // Enqueue outcome codes
  typedef enum logic [2:0] {
    ST_ACCEPTED       = 3'd0,
    ST_DROP_UNKNOWN   = 3'd1,
    ST_DROP_DUP_READY = 3'd2,
    ST_EVICT_READY    = 3'd3,
    ST_EVICT_OLDEST   = 3'd4
  } enq_status_t;

  // Request transaction payload
  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  msg_type;
    logic [15:0] msg_id;
    logic [7:0]  payload_tag;
  } req_t;

  // Response transaction payload
  typedef struct packed {
    logic        out_valid;
    logic [1:0]  out_type;
    logic [15:0] out_id;
    logic [7:0]  out_tag;
    logic [2:0]  enq_status;
    logic [7:0]  evicted_tag;
    logic [4:0]  occupancy;
    logic        has_request;
  } rsp_t;

  // One queued message
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [7:0]  tag;
  } entry_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic   write_en;     // store wr_entry in the cell at the write index
    logic   shift_front;  // every cell takes its right neighbour's entry
    logic   shift_ready;  // cells from the first READY onwards take their neighbour's entry
    entry_t wr_entry;
  } cell_ctl_t;

endpackage

// ----- src/mqre_if.sv -----
// ----------------------------------------------------------------------------
// mqre_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mqre_if #(
  parameter type data_t = logic
);

  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- src/mqre_cell.sv -----
// ----------------------------------------------------------------------------
// mqre_cell
// One queue slot: holds an entry, takes its right neighbour's entry on a
// shift, and passes the READY search and request flag down the chain.
// ----------------------------------------------------------------------------
module mqre_cell
  import mqre_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [CW-1:0] count,
  input  logic [CW-1:0] wr_idx,
  input  entry_t        right,
  input  logic          seen_in,
  input  logic [7:0]    tag_in,
  input  logic          req_in,
  output entry_t        entry,
  output logic          seen_out,
  output logic [7:0]    tag_out,
  output logic          req_out
);

  logic occupied;
  logic ready_hit;
  logic shift;

  // Flag what this slot holds
  assign occupied  = count > CW'(IDX);
  assign ready_hit = occupied && (entry.kind == MT_READY);

  // Carry the first READY and its tag towards the back
  assign seen_out = seen_in | ready_hit;
  assign tag_out  = seen_in ? tag_in : (ready_hit ? entry.tag : 8'd0);
  assign req_out  = req_in | (occupied && (entry.kind == MT_REQUEST));

  // Close the gap left by a removed entry
  assign shift = ctl.shift_front | (ctl.shift_ready & seen_out);

  // Write, shift or hold
  always_ff @(posedge clk) begin
    if (ctl.write_en && (wr_idx == CW'(IDX))) begin
      entry <= ctl.wr_entry;
    end else if (shift) begin
      entry <= right;
    end
  end

endmodule

// ----- src/message_queue_with_ready_eviction_unit.sv -----
// An accepted request's response transaction is presented in the cycle after it is accepted.
// Throughput: one request per cycle while responses are taken; the cell
// chain settles a full READY search, eviction and append combinationally.
// A request is accepted while the response register is empty or being taken.
// Reset clears the entry count and the response valid flag; slot contents are
// left as they are and are never read before they are written.
// ----------------------------------------------------------------------------
// message_queue_with_ready_eviction_unit
// Bounded message queue built as a chain of slot cells, with READY
// de-duplication and eviction of the first READY (or the oldest entry) when
// full.
// ----------------------------------------------------------------------------
module message_queue_with_ready_eviction_unit
  import mqre_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  mqre_if.sink   req,
  mqre_if.source rsp
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        out_valid;
    logic [1:0]  out_type;
    logic [15:0] out_id;
    logic [7:0]  out_tag;
    logic [2:0]  enq_status;
    logic [7:0]  evicted_tag;
  } res_t;

  req_t          rq;
  logic          accept;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] wr_idx;
  logic          full;
  logic          any_ready;
  logic          is_enq;
  logic          drop_unknown;
  logic          drop_dup;
  logic          enq_ok;
  logic          evict_ready;
  logic          evict_oldest;
  logic          deq;
  logic          clr;
  cell_ctl_t     ctl;
  res_t          res;
  res_t          res_next;
  logic          rsp_valid;

  entry_t     cell_entry [QUEUE_DEPTH];
  logic       cell_seen  [QUEUE_DEPTH];
  logic [7:0] cell_tag   [QUEUE_DEPTH];
  logic       cell_req   [QUEUE_DEPTH];

  assign rq        = req.data;
  assign req.ready = !rst && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // Decode the operation against the current queue contents
  assign full         = count == CW'(QUEUE_DEPTH);
  assign any_ready    = cell_seen[QUEUE_DEPTH-1];
  assign is_enq       = rq.opcode == OP_ENQUEUE;
  assign drop_unknown = is_enq && (rq.msg_type == MT_UNKNOWN);
  assign drop_dup     = is_enq && (rq.msg_type == MT_READY) && any_ready;
  assign enq_ok       = is_enq && !drop_unknown && !drop_dup;
  assign evict_ready  = enq_ok && full && any_ready;
  assign evict_oldest = enq_ok && full && !any_ready;
  assign deq          = (rq.opcode == OP_DEQUEUE) && (count != '0);
  assign clr          = rq.opcode == OP_CLEAR;
  assign wr_idx       = full ? CW'(QUEUE_DEPTH - 1) : count;

  // Broadcast cell control
  always_comb begin
    ctl.write_en       = accept && enq_ok;
    ctl.shift_front    = accept && (deq || evict_oldest);
    ctl.shift_ready    = accept && evict_ready;
    ctl.wr_entry.kind  = rq.msg_type;
    ctl.wr_entry.id    = rq.msg_id;
    ctl.wr_entry.tag   = rq.payload_tag;
  end

  // Cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t     right;
    logic       seen_in;
    logic [7:0] tag_in;
    logic       req_in;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = cell_entry[i];
    end else begin : g_mid
      assign right = cell_entry[i+1];
    end

    if (i == 0) begin : g_first
      assign seen_in = 1'b0;
      assign tag_in  = 8'd0;
      assign req_in  = 1'b0;
    end else begin : g_rest
      assign seen_in = cell_seen[i-1];
      assign tag_in  = cell_tag[i-1];
      assign req_in  = cell_req[i-1];
    end

    mqre_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count),
      .wr_idx   (wr_idx),
      .right    (right),
      .seen_in  (seen_in),
      .tag_in   (tag_in),
      .req_in   (req_in),
      .entry    (cell_entry[i]),
      .seen_out (cell_seen[i]),
      .tag_out  (cell_tag[i]),
      .req_out  (cell_req[i])
    );
  end

  // Next occupancy and response fields
  always_comb begin
    count_next = count;
    priority if (clr) begin
      count_next = '0;
    end else if (enq_ok && !full) begin
      count_next = count + CW'(1);
    end else if (deq) begin
      count_next = count - CW'(1);
    end

    res_next = '0;
    if (deq) begin
      res_next.out_valid = 1'b1;
      res_next.out_type  = cell_entry[0].kind;
      res_next.out_id    = cell_entry[0].id;
      res_next.out_tag   = cell_entry[0].tag;
    end
    priority if (drop_unknown) begin
      res_next.enq_status = ST_DROP_UNKNOWN;
    end else if (drop_dup) begin
      res_next.enq_status = ST_DROP_DUP_READY;
    end else if (evict_ready) begin
      res_next.enq_status  = ST_EVICT_READY;
      res_next.evicted_tag = cell_tag[QUEUE_DEPTH-1];
    end else if (evict_oldest) begin
      res_next.enq_status  = ST_EVICT_OLDEST;
      res_next.evicted_tag = cell_entry[0].tag;
    end else begin
      res_next.enq_status = ST_ACCEPTED;
    end
  end

  // Advance occupancy and the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  // Occupancy and request flag come straight from the state, which holds
  // while a response waits
  assign rsp.valid = rsp_valid;
  always_comb begin
    rsp.data.out_valid   = res.out_valid;
    rsp.data.out_type    = res.out_type;
    rsp.data.out_id      = res.out_id;
    rsp.data.out_tag     = res.out_tag;
    rsp.data.enq_status  = res.enq_status;
    rsp.data.evicted_tag = res.evicted_tag;
    rsp.data.occupancy   = 5'(count);
    rsp.data.has_request = cell_req[QUEUE_DEPTH-1];
  end

endmodule

// ----- src/mqre_chk.sv -----
// ----------------------------------------------------------------------------
// mqre_chk
// Port-level checks on the message queue, bound to the top level.
// ----------------------------------------------------------------------------
module mqre_chk
  import mqre_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req_data,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // Every accepted request yields a response in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("response missing after accepted request");

  // A stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // Clear empties the queue
  a_clear: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_data.opcode == OP_CLEAR)
    |=> rsp_data.occupancy == 5'd0 && !rsp_data.has_request)
    else $error("queue not empty after clear");

  // Eviction only happens on a full queue, which stays full
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.enq_status == ST_EVICT_READY ||
                  rsp_data.enq_status == ST_EVICT_OLDEST)
    |-> rsp_data.occupancy == 5'(QUEUE_DEPTH) && !rsp_data.out_valid)
    else $error("eviction reported without a full queue");

  // A dequeue response carries no enqueue outcome
  a_deq_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.out_valid
    |-> rsp_data.enq_status == ST_ACCEPTED && rsp_data.evicted_tag == 8'd0)
    else $error("dequeue response mixed with enqueue outcome");

endmodule

bind message_queue_with_ready_eviction_unit mqre_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mqre_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_data  (req.data),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
